// ===== rtl/core/cau_pkg.sv =====
// shared codes and pipeline control type for the complex arithmetic unit
`default_nettype none
package cau_pkg;

  // operation kinds
  localparam logic [2:0] KIND_ADD  = 3'd0;
  localparam logic [2:0] KIND_SUB  = 3'd1;
  localparam logic [2:0] KIND_MUL  = 3'd2;
  localparam logic [2:0] KIND_DIVC = 3'd3;
  localparam logic [2:0] KIND_DIVR = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DIVZERO = 2'd1;
  localparam logic [1:0] ST_SAT     = 2'd2;

  // control that travels with each beat down the pipe
  typedef struct packed {
    logic valid;
    logic divzero;
    logic use_div;
    logic neg_r;
    logic neg_i;
    logic over_r;
    logic over_i;
  } ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/complex_arithmetic_unit.sv =====
// top level of the pipelined complex arithmetic unit
`default_nettype none
// complex arithmetic unit: add, subtract, multiply, divide by complex, divide by real
//
// input channel: a beat (kind and both complex operands) is taken at a rising
//   edge with start high and busy low; busy is always low, the pipe never stalls
// output channel: done is high for exactly one cycle with r_real, r_imag and
//   status; the receiver cannot stall, so every result is taken as it appears
// throughput: one beat per cycle; every stage is a register stage and the
//   divider spends one pipeline stage per quotient bit, WIDTH stages in all
// stages: input register, six parallel products, numerator and divisor select,
//   divider setup with fit check, WIDTH quotient stages, saturation and output
// reset: synchronous; clears every valid bit so no stale beat is delivered,
//   operand and result payloads are left as they are
// status: ok, divide by zero (both parts zero) or saturated (either part)
module complex_arithmetic_unit #(
  parameter int WIDTH = 16,
  parameter int FRAC  = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              kind,
  input  logic signed [WIDTH-1:0] a_real,
  input  logic signed [WIDTH-1:0] a_imag,
  input  logic signed [WIDTH-1:0] b_real,
  input  logic signed [WIDTH-1:0] b_imag,
  output logic                    done,
  output logic signed [WIDTH-1:0] r_real,
  output logic signed [WIDTH-1:0] r_imag,
  output logic [1:0]              status
);
  import cau_pkg::*;

  localparam int DW      = 2 * WIDTH;
  localparam int LATENCY = WIDTH + 5;
  // most negative and most positive results
  localparam logic [WIDTH-1:0] MIN_V = {1'b1, {(WIDTH-1){1'b0}}};
  localparam logic [WIDTH-1:0] MAX_V = {1'b0, {(WIDTH-1){1'b1}}};

  // the pipe never holds off a beat
  assign busy = 1'b0;

  // stage 0: input register
  logic                    v0;
  logic [2:0]              k0;
  logic signed [WIDTH-1:0] ar0, ai0, br0, bi0;

  always_ff @(posedge clk) begin
    k0  <= kind;
    ar0 <= a_real;
    ai0 <= a_imag;
    br0 <= b_real;
    bi0 <= b_imag;
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
  end

  // stage 1: products, plain sums, operand magnitudes
  logic                  v1;
  logic [2:0]            k1;
  logic signed [DW-1:0]  p_rr, p_ii, p_ri, p_ir, p_bbr, p_bbi;
  logic signed [WIDTH:0] sum_r, sum_i;
  logic [WIDTH-1:0]      mag_ar, mag_ai, mag_br;
  logic                  sgn_ar, sgn_ai, sgn_br;

  always_ff @(posedge clk) begin
    k1    <= k0;
    p_rr  <= ar0 * br0;
    p_ii  <= ai0 * bi0;
    p_ri  <= ar0 * bi0;
    p_ir  <= ai0 * br0;
    p_bbr <= br0 * br0;
    p_bbi <= bi0 * bi0;
    sum_r <= (k0 == KIND_SUB) ? ar0 - br0 : ar0 + br0;
    sum_i <= (k0 == KIND_SUB) ? ai0 - bi0 : ai0 + bi0;
    // magnitude of the most negative value still fits unsigned
    mag_ar <= ar0[WIDTH-1] ? (~ar0 + 1'b1) : ar0;
    mag_ai <= ai0[WIDTH-1] ? (~ai0 + 1'b1) : ai0;
    mag_br <= br0[WIDTH-1] ? (~br0 + 1'b1) : br0;
    sgn_ar <= ar0[WIDTH-1];
    sgn_ai <= ai0[WIDTH-1];
    sgn_br <= br0[WIDTH-1];
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
  end

  // stage 2: pick numerators, divisor and bypass quotients per kind
  logic signed [DW:0] e_r, e_i;
  logic [DW:0]        m_r, m_i;
  logic [WIDTH:0]     ms_r, ms_i;
  logic [DW-1:0]      sh_r, sh_i;
  logic [DW-1:0]      den_c;
  ctl_t               ctl_next;
  logic [DW-1:0]      num_r_next, num_i_next, den_next;
  logic [WIDTH-1:0]   q_r_next, q_i_next;

  always_comb begin
    // exact cross sums, one wider than a product
    e_r = '0;
    e_i = '0;
    if (k1 == KIND_MUL) begin
      e_r = {p_rr[DW-1], p_rr} - {p_ii[DW-1], p_ii};
      e_i = {p_ri[DW-1], p_ri} + {p_ir[DW-1], p_ir};
    end else begin
      e_r = {p_rr[DW-1], p_rr} + {p_ii[DW-1], p_ii};
      e_i = {p_ir[DW-1], p_ir} - {p_ri[DW-1], p_ri};
    end
    m_r   = e_r[DW] ? (~e_r + 1'b1) : e_r;
    m_i   = e_i[DW] ? (~e_i + 1'b1) : e_i;
    sh_r  = m_r[DW-1:0] >> FRAC;
    sh_i  = m_i[DW-1:0] >> FRAC;
    ms_r  = sum_r[WIDTH] ? (~sum_r + 1'b1) : sum_r;
    ms_i  = sum_i[WIDTH] ? (~sum_i + 1'b1) : sum_i;
    // squares are never negative
    den_c = $unsigned(p_bbr) + $unsigned(p_bbi);

    ctl_next       = '0;
    ctl_next.valid = v1;
    num_r_next     = '0;
    num_i_next     = '0;
    den_next       = '0;
    q_r_next       = '0;
    q_i_next       = '0;
    unique case (k1)
      KIND_ADD, KIND_SUB: begin
        ctl_next.neg_r  = sum_r[WIDTH];
        ctl_next.neg_i  = sum_i[WIDTH];
        ctl_next.over_r = ms_r[WIDTH];
        ctl_next.over_i = ms_i[WIDTH];
        q_r_next        = ms_r[WIDTH-1:0];
        q_i_next        = ms_i[WIDTH-1:0];
      end
      KIND_MUL: begin
        ctl_next.neg_r  = e_r[DW];
        ctl_next.neg_i  = e_i[DW];
        ctl_next.over_r = (sh_r >> WIDTH) != '0;
        ctl_next.over_i = (sh_i >> WIDTH) != '0;
        q_r_next        = sh_r[WIDTH-1:0];
        q_i_next        = sh_i[WIDTH-1:0];
      end
      KIND_DIVC: begin
        if (den_c == '0) begin
          ctl_next.divzero = 1'b1;
        end else begin
          ctl_next.use_div = 1'b1;
          ctl_next.neg_r   = e_r[DW];
          ctl_next.neg_i   = e_i[DW];
          num_r_next       = m_r[DW-1:0];
          num_i_next       = m_i[DW-1:0];
          den_next         = den_c;
        end
      end
      KIND_DIVR: begin
        if (mag_br == '0) begin
          ctl_next.divzero = 1'b1;
        end else begin
          ctl_next.use_div = 1'b1;
          ctl_next.neg_r   = sgn_ar ^ sgn_br;
          ctl_next.neg_i   = sgn_ai ^ sgn_br;
          num_r_next       = DW'(mag_ar);
          num_i_next       = DW'(mag_ai);
          den_next         = DW'(mag_br);
        end
      end
      default: begin
        // unused kinds give a zero result with ok status
      end
    endcase
  end

  ctl_t             ctl2;
  logic [DW-1:0]    num_r2, num_i2, den2;
  logic [WIDTH-1:0] q_r2, q_i2;

  always_ff @(posedge clk) begin
    ctl2   <= rst ? '0 : ctl_next;
    num_r2 <= num_r_next;
    num_i2 <= num_i_next;
    den2   <= den_next;
    q_r2   <= q_r_next;
    q_i2   <= q_i_next;
  end

  // divider: setup stage plus one stage per quotient bit
  ctl_t             ctl_d;
  logic [WIDTH-1:0] q_r_d, q_i_d;

  cau_div #(
    .WIDTH(WIDTH),
    .FRAC (FRAC)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .in_ctl (ctl2),
    .num_r  (num_r2),
    .num_i  (num_i2),
    .den    (den2),
    .q_r_in (q_r2),
    .q_i_in (q_i2),
    .out_ctl(ctl_d),
    .q_r    (q_r_d),
    .q_i    (q_i_d)
  );

  // final stage: saturate each part and form the status
  logic sat_r, sat_i;

  always_comb begin
    sat_r = ctl_d.over_r || (ctl_d.neg_r ? (q_r_d > MIN_V) : (q_r_d > MAX_V));
    sat_i = ctl_d.over_i || (ctl_d.neg_i ? (q_i_d > MIN_V) : (q_i_d > MAX_V));
  end

  always_ff @(posedge clk) begin
    if (ctl_d.neg_r) begin
      r_real <= sat_r ? MIN_V : (~q_r_d + 1'b1);
    end else begin
      r_real <= sat_r ? MAX_V : q_r_d;
    end
    if (ctl_d.neg_i) begin
      r_imag <= sat_i ? MIN_V : (~q_i_d + 1'b1);
    end else begin
      r_imag <= sat_i ? MAX_V : q_i_d;
    end
    priority if (ctl_d.divzero) begin
      status <= ST_DIVZERO;
    end else if (sat_r || sat_i) begin
      status <= ST_SAT;
    end else begin
      status <= ST_OK;
    end
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_d.valid;
    end
  end

`ifndef SYNTH
  // every accepted beat comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result missing at fixed latency");

  // a zero divisor clears both parts
  a_divzero_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_DIVZERO) |-> (r_real == '0 && r_imag == '0))
    else $error("divide by zero with non-zero result");

  // a saturated result has at least one part at a limit
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_SAT) |->
      (r_real == MIN_V || r_real == MAX_V || r_imag == MIN_V || r_imag == MAX_V))
    else $error("saturated status without a part at a limit");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/cau_div.sv =====
// pipelined restoring fraction divider, one quotient bit per stage
`default_nettype none
module cau_div #(
  parameter int WIDTH = 16,
  parameter int FRAC  = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cau_pkg::ctl_t        in_ctl,
  input  logic [2*WIDTH-1:0]   num_r,
  input  logic [2*WIDTH-1:0]   num_i,
  input  logic [2*WIDTH-1:0]   den,
  input  logic [WIDTH-1:0]     q_r_in,
  input  logic [WIDTH-1:0]     q_i_in,
  output cau_pkg::ctl_t        out_ctl,
  output logic [WIDTH-1:0]     q_r,
  output logic [WIDTH-1:0]     q_i
);
  import cau_pkg::*;

  localparam int DW = 2 * WIDTH;
  localparam int RW = 2 * WIDTH + FRAC;
  localparam int CW = 3 * WIDTH + FRAC;

  ctl_t             ctl   [WIDTH+1];
  logic [WIDTH-1:0] qr    [WIDTH+1];
  logic [WIDTH-1:0] qi    [WIDTH+1];
  logic [RW-1:0]    rem_r [WIDTH];
  logic [RW-1:0]    rem_i [WIDTH];
  logic [DW-1:0]    d     [WIDTH];

  // setup: scale numerators, flag quotients that cannot fit
  logic [RW-1:0] xr, xi;
  logic [CW-1:0] dtop;
  ctl_t          setup_ctl;

  always_comb begin
    xr = RW'(num_r) << FRAC;
    xi = RW'(num_i) << FRAC;
    dtop = CW'(den) << WIDTH;
    setup_ctl = in_ctl;
    if (in_ctl.use_div) begin
      setup_ctl.over_r = CW'(xr) >= dtop;
      setup_ctl.over_i = CW'(xi) >= dtop;
    end
  end

  always_ff @(posedge clk) begin
    ctl[0]   <= rst ? '0 : setup_ctl;
    qr[0]    <= q_r_in;
    qi[0]    <= q_i_in;
    rem_r[0] <= xr;
    rem_i[0] <= xi;
    d[0]     <= den;
  end

  for (genvar s = 0; s < WIDTH; s++) begin : g_stage
    localparam int K = WIDTH - 1 - s;
    logic [CW-1:0] dk, tr, ti;
    logic          hit_r, hit_i;

    always_comb begin
      dk    = CW'(d[s]) << K;
      tr    = CW'(rem_r[s]);
      ti    = CW'(rem_i[s]);
      hit_r = ctl[s].use_div && (tr >= dk);
      hit_i = ctl[s].use_div && (ti >= dk);
    end

    always_ff @(posedge clk) begin
      ctl[s+1] <= rst ? '0 : ctl[s];
      qr[s+1]  <= qr[s] | (WIDTH'(hit_r) << K);
      qi[s+1]  <= qi[s] | (WIDTH'(hit_i) << K);
    end

    if (s + 1 < WIDTH) begin : g_rem
      always_ff @(posedge clk) begin
        rem_r[s+1] <= hit_r ? RW'(tr - dk) : rem_r[s];
        rem_i[s+1] <= hit_i ? RW'(ti - dk) : rem_i[s];
        d[s+1]     <= d[s];
      end
    end
  end

  assign out_ctl = ctl[WIDTH];
  assign q_r     = qr[WIDTH];
  assign q_i     = qi[WIDTH];

endmodule
`default_nettype wire
